/* hw/rtl/bph_pkg.sv */
// ----------------------------------------------------------------------------
// bph_pkg
// Shared types, codes and helpers of the binary projection histogram.
// ----------------------------------------------------------------------------
package bph_pkg;

  localparam int CW = 11;

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_COL   = 2'd1;
  localparam logic [1:0] CMD_ROW   = 2'd2;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_BIN,
    ST_DPREP,
    ST_DIV,
    ST_SUM,
    ST_THR,
    ST_THM,
    ST_STILL,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_BIN,
    PH_COL,
    PH_ROW
  } phase_t;

  // floor(v/10) for v below 8192
  function automatic logic [12:0] div10(input logic [12:0] v);
    logic [25:0] p;
    p = 26'(v) * 26'd6554;
    return p[25:16] == 10'd0 ? 13'd0 : 13'(p[25:16]);
  endfunction

endpackage

/* hw/rtl/binary_projection_histogram_top.sv */
// ----------------------------------------------------------------------------
// binary_projection_histogram_top
// Column and row white-pixel projections of a binary frame, kept in two
// block memories, with end-of-frame averages, still flags and bin reads.
//
//  channel | ports                              | transaction
//  in      | start, busy, in_*                  | start & !busy
//  out     | out_valid, out_*                   | out_valid (one cycle)
//  cfg     | cfg_valid, cfg_ready, cfg_index/wdata | cfg_valid & cfg_ready
//
// A pixel reads its column, then writes it back.
// A bin read passes ST_BIN, ST_DPREP and the serial divider over the NORM_SCALE bit width.
// The last pixel of a frame starts two passes over both memories (ST_SUM and
// ST_STILL) and two divisions; busy stays high throughout.
// Reset is synchronous; memories are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module binary_projection_histogram_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int NORM_SCALE  = 500
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_pixel,
  input  logic [9:0]  in_bin_index,
  output logic        out_valid,
  output logic        out_kind,
  output logic [8:0]  out_bin_value,
  output logic [8:0]  out_column_average,
  output logic [8:0]  out_row_average,
  output logic        out_columns_still,
  output logic        out_rows_still,
  output logic [20:0] out_white_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int CW   = bph_pkg::CW;
  localparam int XW   = $clog2(MAX_COLUMNS);
  localparam int YW   = $clog2(MAX_ROWS);
  localparam int NCW  = $clog2(MAX_COLUMNS + 1);
  localparam int NRW  = $clog2(MAX_ROWS + 1);
  localparam int NMW  = (NCW > NRW) ? NCW : NRW;
  localparam int SCW  = $clog2(NORM_SCALE + 1);
  localparam int BW   = $clog2(SCW + 1);
  localparam int SW   = CW + NMW;
  localparam int DW   = CW + NMW;
  localparam int NW   = SW + SCW;
  localparam int EW   = (NW > DW + SCW) ? NW : DW + SCW;
  localparam int PW   = CW + SCW;

  logic [CW-1:0] col_mem [MAX_COLUMNS];
  logic [CW-1:0] row_mem [MAX_ROWS];
  logic [CW-1:0] col_rd_r, row_rd_r;
  logic [XW-1:0] col_ra;
  logic [YW-1:0] row_ra;
  logic          col_we, row_we;
  logic [CW-1:0] col_wd, row_wd;

  bph_pkg::state_t state_r, state_nxt;
  bph_pkg::phase_t phase_r, phase_nxt;

  logic [10:0]    width_r, width_nxt, height_r, height_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [YW-1:0]  y_r, y_nxt;
  logic [CW-1:0]  cur_r, cur_nxt, maxc_r, maxc_nxt, maxr_r, maxr_nxt;
  logic [20:0]    white_r, white_nxt;

  logic [1:0]     cmd_r, cmd_nxt;
  logic           wpx_r, wpx_nxt;
  logic           inr_r, inr_nxt;

  logic [SW-1:0]  a_r, a_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic           fz_r, fz_nxt, sat_r, sat_nxt, zero_r, zero_nxt;
  logic [EW-1:0]  rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [SCW-1:0] q_r, q_nxt;
  logic [BW-1:0]  bit_r, bit_nxt;

  logic [NMW-1:0] i_r, i_nxt, id_r, id_nxt;
  logic           vld_r, vld_nxt;
  logic [SW-1:0]  sumc_r, sumc_nxt, sumr_r, sumr_nxt;
  logic [SCW-1:0] avgc_r, avgc_nxt, avgr_r, avgr_nxt;
  logic [PW-1:0]  thrc_r, thrc_nxt, thrr_r, thrr_nxt;
  logic [PW-1:0]  thmc_r, thmc_nxt, thmr_r, thmr_nxt;
  logic [NMW-1:0] abc_r, abc_nxt, abr_r, abr_nxt;

  logic           ov_r, ov_nxt, ok_r, ok_nxt, ocs_r, ocs_nxt, ors_r, ors_nxt;
  logic [8:0]     obv_r, obv_nxt, oca_r, oca_nxt, ora_r, ora_nxt;
  logic [20:0]    owt_r, owt_nxt;

  logic [NCW-1:0] w;
  logic [NRW-1:0] h;
  logic [NMW-1:0] nmax;

  always_comb begin
    if (width_r == 11'd0) w = NCW'(1);
    else if (32'(width_r) > MAX_COLUMNS) w = NCW'(MAX_COLUMNS);
    else w = NCW'(width_r);
    if (height_r == 11'd0) h = NRW'(1);
    else if (32'(height_r) > MAX_ROWS) h = NRW'(MAX_ROWS);
    else h = NRW'(height_r);
    nmax = (32'(w) > 32'(h)) ? NMW'(w) : NMW'(h);
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != bph_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (col_we) col_mem[x_r] <= col_wd;
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[y_r] <= row_wd;
    row_rd_r <= row_mem[row_ra];
  end

  always_comb begin
    logic           first, last_row, issue;
    logic [CW-1:0]  ncol, ncur, mcb, mrb;
    logic [20:0]    wb;
    logic [SCW-1:0] qn, res;

    state_nxt  = state_r;   phase_nxt = phase_r;
    width_nxt  = width_r;   height_nxt = height_r;
    x_nxt = x_r; y_nxt = y_r; cur_nxt = cur_r;
    maxc_nxt = maxc_r; maxr_nxt = maxr_r; white_nxt = white_r;
    cmd_nxt = cmd_r; wpx_nxt = wpx_r; inr_nxt = inr_r;
    a_nxt = a_r; d_nxt = d_r; fz_nxt = fz_r; sat_nxt = sat_r; zero_nxt = zero_r;
    rem_nxt = rem_r; dsh_nxt = dsh_r; q_nxt = q_r; bit_nxt = bit_r;
    i_nxt = i_r; id_nxt = id_r; vld_nxt = vld_r;
    sumc_nxt = sumc_r; sumr_nxt = sumr_r; avgc_nxt = avgc_r; avgr_nxt = avgr_r;
    thrc_nxt = thrc_r; thrr_nxt = thrr_r; thmc_nxt = thmc_r; thmr_nxt = thmr_r;
    abc_nxt = abc_r; abr_nxt = abr_r;
    ov_nxt = 1'b0; ok_nxt = ok_r; obv_nxt = obv_r; oca_nxt = oca_r; ora_nxt = ora_r;
    ocs_nxt = ocs_r; ors_nxt = ors_r; owt_nxt = owt_r;
    col_ra = x_r; row_ra = y_r;
    col_we = 1'b0; row_we = 1'b0;
    col_wd = '0;   row_wd = '0;
    first = (x_r == '0) && (y_r == '0);
    last_row = (32'(y_r) + 32'd1 >= 32'(h));
    issue = (32'(i_r) < 32'(nmax));
    ncol = '0; ncur = '0; mcb = '0; mrb = '0; wb = '0; qn = '0; res = '0;

    if (cfg_valid) begin
      if (cfg_index == bph_pkg::REG_FRAME_WIDTH) width_nxt = cfg_wdata;
      else if (cfg_index == bph_pkg::REG_FRAME_HEIGHT) height_nxt = cfg_wdata;
    end

    unique case (state_r)
      bph_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          wpx_nxt = (in_pixel == 8'd255);
          case (in_cmd)
            bph_pkg::CMD_PIXEL: begin
              state_nxt = bph_pkg::ST_PIX;
            end
            bph_pkg::CMD_COL: begin
              col_ra = XW'(in_bin_index);
              inr_nxt = (32'(in_bin_index) < 32'(w));
              state_nxt = bph_pkg::ST_BIN;
            end
            bph_pkg::CMD_ROW: begin
              row_ra = YW'(in_bin_index);
              inr_nxt = (32'(in_bin_index) < 32'(h));
              state_nxt = bph_pkg::ST_BIN;
            end
            default: ;
          endcase
        end
      end
      bph_pkg::ST_PIX: begin
        ncol = (y_r == '0) ? CW'(wpx_r) : col_rd_r + CW'(wpx_r);
        ncur = cur_r + CW'(wpx_r);
        wb   = first ? 21'd0 : white_r;
        mcb  = first ? '0 : maxc_r;
        mrb  = first ? '0 : maxr_r;
        white_nxt = wb + 21'(wpx_r);
        col_we = 1'b1;
        col_wd = ncol;
        maxc_nxt = (last_row && ncol > mcb) ? ncol : mcb;
        maxr_nxt = mrb;
        cur_nxt = ncur;
        state_nxt = bph_pkg::ST_IDLE;
        if (32'(x_r) + 32'd1 >= 32'(w)) begin
          row_we = 1'b1;
          row_wd = ncur;
          if (ncur > mrb) maxr_nxt = ncur;
          cur_nxt = '0;
          x_nxt = '0;
          if (last_row) begin
            y_nxt = '0;
            i_nxt = '0;
            vld_nxt = 1'b0;
            sumc_nxt = '0;
            sumr_nxt = '0;
            state_nxt = bph_pkg::ST_SUM;
          end else begin
            y_nxt = y_r + YW'(1);
          end
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      bph_pkg::ST_BIN: begin
        a_nxt = (cmd_r == bph_pkg::CMD_COL) ? SW'(col_rd_r) : SW'(row_rd_r);
        d_nxt = (cmd_r == bph_pkg::CMD_COL) ? DW'(maxc_r) : DW'(maxr_r);
        fz_nxt = !inr_r;
        phase_nxt = bph_pkg::PH_BIN;
        state_nxt = bph_pkg::ST_DPREP;
      end
      bph_pkg::ST_DPREP: begin
        rem_nxt = EW'(a_r) * EW'(NORM_SCALE);
        sat_nxt = (a_r > d_r);
        zero_nxt = (d_r == '0) || fz_r;
        dsh_nxt = EW'(d_r) << (SCW - 1);
        q_nxt = '0;
        bit_nxt = BW'(SCW - 1);
        state_nxt = bph_pkg::ST_DIV;
      end
      bph_pkg::ST_DIV: begin
        qn = q_r;
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          qn = q_r | (SCW'(1) << bit_r);
        end
        q_nxt = qn;
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - BW'(1);
        res = zero_r ? '0 : (sat_r ? SCW'(NORM_SCALE) : qn);
        if (bit_r == '0) begin
          case (phase_r)
            bph_pkg::PH_BIN: begin
              ov_nxt = 1'b1;
              ok_nxt = bph_pkg::KIND_BIN;
              obv_nxt = 9'(res);
              oca_nxt = '0; ora_nxt = '0; ocs_nxt = 1'b0; ors_nxt = 1'b0;
              owt_nxt = '0;
              state_nxt = bph_pkg::ST_IDLE;
            end
            bph_pkg::PH_COL: begin
              avgc_nxt = res;
              a_nxt = sumr_r;
              d_nxt = DW'(maxr_r) * DW'(h);
              fz_nxt = 1'b0;
              phase_nxt = bph_pkg::PH_ROW;
              state_nxt = bph_pkg::ST_DPREP;
            end
            default: begin
              avgr_nxt = res;
              state_nxt = bph_pkg::ST_THR;
            end
          endcase
        end
      end
      bph_pkg::ST_SUM: begin
        col_ra = XW'(i_r);
        row_ra = YW'(i_r);
        vld_nxt = issue;
        id_nxt = i_r;
        if (issue) i_nxt = i_r + NMW'(1);
        if (vld_r) begin
          if (32'(id_r) < 32'(w)) sumc_nxt = sumc_r + SW'(col_rd_r);
          if (32'(id_r) < 32'(h)) sumr_nxt = sumr_r + SW'(row_rd_r);
        end
        if (!issue && !vld_r) begin
          a_nxt = sumc_r;
          d_nxt = DW'(maxc_r) * DW'(w);
          fz_nxt = 1'b0;
          phase_nxt = bph_pkg::PH_COL;
          state_nxt = bph_pkg::ST_DPREP;
        end
      end
      bph_pkg::ST_THR: begin
        thrc_nxt = PW'(bph_pkg::div10(13'(avgc_r))) * PW'(5);
        thrr_nxt = PW'(bph_pkg::div10(13'(avgr_r))) * PW'(5);
        state_nxt = bph_pkg::ST_THM;
      end
      bph_pkg::ST_THM: begin
        thmc_nxt = thrc_r * PW'(maxc_r);
        thmr_nxt = thrr_r * PW'(maxr_r);
        i_nxt = '0;
        vld_nxt = 1'b0;
        abc_nxt = '0;
        abr_nxt = '0;
        state_nxt = bph_pkg::ST_STILL;
      end
      bph_pkg::ST_STILL: begin
        col_ra = XW'(i_r);
        row_ra = YW'(i_r);
        vld_nxt = issue;
        id_nxt = i_r;
        if (issue) i_nxt = i_r + NMW'(1);
        if (vld_r) begin
          if (32'(id_r) < 32'(w) && maxc_r != '0 &&
              PW'(col_rd_r) * PW'(NORM_SCALE) > thmc_r)
            abc_nxt = abc_r + NMW'(1);
          if (32'(id_r) < 32'(h) && maxr_r != '0 &&
              PW'(row_rd_r) * PW'(NORM_SCALE) > thmr_r)
            abr_nxt = abr_r + NMW'(1);
        end
        if (!issue && !vld_r) state_nxt = bph_pkg::ST_FIN;
      end
      bph_pkg::ST_FIN: begin
        ov_nxt = 1'b1;
        ok_nxt = bph_pkg::KIND_SUMMARY;
        obv_nxt = '0;
        oca_nxt = 9'(avgc_r);
        ora_nxt = 9'(avgr_r);
        ocs_nxt = (32'(abc_r) > 32'(bph_pkg::div10(13'(w))) * 32'd7);
        ors_nxt = (32'(abr_r) > 32'(bph_pkg::div10(13'(h))) * 32'd7);
        owt_nxt = white_r;
        state_nxt = bph_pkg::ST_IDLE;
      end
      default: state_nxt = bph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bph_pkg::ST_IDLE;
      phase_r  <= bph_pkg::PH_BIN;
      width_r  <= 11'd640;
      height_r <= 11'd480;
      x_r      <= '0;
      y_r      <= '0;
      cur_r    <= '0;
      maxc_r   <= '0;
      maxr_r   <= '0;
      white_r  <= '0;
      ov_r     <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      cur_r    <= cur_nxt;
      maxc_r   <= maxc_nxt;
      maxr_r   <= maxr_nxt;
      white_r  <= white_nxt;
      ov_r     <= ov_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;   wpx_r <= wpx_nxt;   inr_r <= inr_nxt;
    a_r <= a_nxt;       d_r <= d_nxt;       fz_r <= fz_nxt;
    sat_r <= sat_nxt;   zero_r <= zero_nxt;
    rem_r <= rem_nxt;   dsh_r <= dsh_nxt;   q_r <= q_nxt;   bit_r <= bit_nxt;
    i_r <= i_nxt;       id_r <= id_nxt;
    sumc_r <= sumc_nxt; sumr_r <= sumr_nxt;
    avgc_r <= avgc_nxt; avgr_r <= avgr_nxt;
    thrc_r <= thrc_nxt; thrr_r <= thrr_nxt;
    thmc_r <= thmc_nxt; thmr_r <= thmr_nxt;
    abc_r <= abc_nxt;   abr_r <= abr_nxt;
    ok_r <= ok_nxt;     obv_r <= obv_nxt;
    oca_r <= oca_nxt;   ora_r <= ora_nxt;
    ocs_r <= ocs_nxt;   ors_r <= ors_nxt;   owt_r <= owt_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kind           = ok_r;
  assign out_bin_value      = obv_r;
  assign out_column_average = oca_r;
  assign out_row_average    = ora_r;
  assign out_columns_still  = ocs_r;
  assign out_rows_still     = ors_r;
  assign out_white_total    = owt_r;

endmodule

/* test/binary_projection_histogram_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_projection_histogram_top_tb
// Drives binary frames, bin reads and geometry writes into the projection
// histogram and checks every summary and bin answer against a local model
// of the counters, maxima, averages and still flags.
// ----------------------------------------------------------------------------
module binary_projection_histogram_top_tb;

  localparam int NCOL = 1024;
  localparam int NROW = 1024;
  localparam int SCALE = 500;
  localparam int STALL_LIMIT = 40000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [8:0]  bin_value;
    logic [8:0]  col_avg;
    logic [8:0]  row_avg;
    logic        col_still;
    logic        row_still;
    logic [20:0] whites;
  } hist_result_t;

  class histogram_scoreboard;
    logic [10:0] width_reg, height_reg;
    logic [10:0] col_cnt [NCOL];
    logic [10:0] row_cnt [NROW];
    bit col_wr [NCOL];
    bit row_wr [NROW];
    int unsigned xpos, ypos, row_acc, col_max, row_max, whites;
    hist_result_t awaited[$];
    int unsigned errors;

    function void clear();
      width_reg = 11'd640;
      height_reg = 11'd480;
      xpos = 0; ypos = 0; row_acc = 0; col_max = 0; row_max = 0; whites = 0;
      errors = 0;
      foreach (col_wr[i]) col_wr[i] = 0;
      foreach (row_wr[i]) row_wr[i] = 0;
    endfunction

    function int unsigned used_dim(logic [10:0] r, int unsigned hi);
      if (r == 0) return 1;
      if (r > hi) return hi;
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
      if (idx == bph_pkg::REG_FRAME_WIDTH) width_reg = val;
      else if (idx == bph_pkg::REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    function logic [8:0] scaled(int unsigned cnt, int unsigned mx);
      longint unsigned q;
      if (mx == 0) return 0;
      q = (longint'(cnt) * SCALE) / mx;
      if (q > SCALE) q = SCALE;
      return q[8:0];
    endfunction

    function void summarise(bit col_axis, int unsigned n, int unsigned mx,
                            output logic [8:0] avg, output logic still);
      longint unsigned total, q, thr, v;
      int unsigned above;
      total = 0;
      above = 0;
      for (int i = 0; i < n; i++) total += col_axis ? col_cnt[i] : row_cnt[i];
      if (mx == 0) q = 0;
      else begin
        q = (total * SCALE) / (longint'(mx) * n);
        if (q > SCALE) q = SCALE;
      end
      thr = (q / 10) * 5;
      for (int i = 0; i < n; i++) begin
        v = col_axis ? col_cnt[i] : row_cnt[i];
        if (mx != 0 && v * SCALE > thr * mx) above++;
      end
      avg = q[8:0];
      still = above > (n / 10) * 7;
    endfunction

    // index that is either out of range or already written
    function logic [9:0] legal_index(bit col_axis);
      int unsigned n, i;
      n = col_axis ? used_dim(width_reg, NCOL) : used_dim(height_reg, NROW);
      repeat (24) begin
        i = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 1023 :
                              ((n + 1 > 1023) ? 1023 : n + 1));
        if (i >= n || (col_axis ? col_wr[i] : row_wr[i])) return i[9:0];
      end
      return 10'd0;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] pix, logic [9:0] idx);
      int unsigned w, h, x, y, wh;
      bit last_row;
      hist_result_t r;
      w = used_dim(width_reg, NCOL);
      h = used_dim(height_reg, NROW);
      r = '0;
      if (cmd == bph_pkg::CMD_COL || cmd == bph_pkg::CMD_ROW) begin
        r.kind = bph_pkg::KIND_BIN;
        if (cmd == bph_pkg::CMD_COL && idx < w)
          r.bin_value = scaled(col_cnt[idx], col_max);
        if (cmd == bph_pkg::CMD_ROW && idx < h)
          r.bin_value = scaled(row_cnt[idx], row_max);
        awaited.push_back(r);
        return;
      end
      if (cmd != bph_pkg::CMD_PIXEL) return;
      x = (xpos >= NCOL) ? NCOL - 1 : xpos;
      y = (ypos >= NROW) ? NROW - 1 : ypos;
      wh = (pix == 8'd255);
      if (x == 0 && y == 0) begin
        whites = 0; col_max = 0; row_max = 0;
      end
      last_row = (y + 1 >= h);
      if (y == 0) begin
        col_cnt[x] = 11'(wh);
        col_wr[x] = 1;
      end else col_cnt[x] = col_cnt[x] + 11'(wh);
      row_acc = (row_acc + wh) & 11'h7ff;
      whites = (whites + wh) & 21'h1fffff;
      if (last_row && col_cnt[x] > col_max) col_max = col_cnt[x];
      if (x + 1 >= w) begin
        row_cnt[y] = 11'(row_acc);
        row_wr[y] = 1;
        if (row_acc > row_max) row_max = row_acc;
        row_acc = 0;
        xpos = 0;
        if (last_row) begin
          ypos = 0;
          r.kind = bph_pkg::KIND_SUMMARY;
          summarise(1, w, col_max, r.col_avg, r.col_still);
          summarise(0, h, row_max, r.row_avg, r.row_still);
          r.whites = 21'(whites);
          awaited.push_back(r);
        end else ypos = y + 1;
      end else xpos = x + 1;
    endfunction

    function void check_result(hist_result_t got);
      hist_result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d", got.kind);
        return;
      end
      exp = awaited.pop_front();
      if (got.kind != exp.kind || got.bin_value != exp.bin_value ||
          got.col_avg != exp.col_avg || got.row_avg != exp.row_avg ||
          got.col_still != exp.col_still || got.row_still != exp.row_still ||
          got.whites != exp.whites) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp k%0d b%0d ca%0d ra%0d cs%0d rs%0d wt%0d",
                    " / got k%0d b%0d ca%0d ra%0d cs%0d rs%0d wt%0d"},
                   exp.kind, exp.bin_value, exp.col_avg, exp.row_avg, exp.col_still,
                   exp.row_still, exp.whites, got.kind, got.bin_value, got.col_avg,
                   got.row_avg, got.col_still, got.row_still, got.whites);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = bph_pkg::CMD_PIXEL;
  logic [7:0]  in_pixel = 8'd0;
  logic [9:0]  in_bin_index = 10'd0;
  logic        out_valid, out_kind, out_columns_still, out_rows_still;
  logic [8:0]  out_bin_value, out_column_average, out_row_average;
  logic [20:0] out_white_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = bph_pkg::REG_FRAME_WIDTH;
  logic [10:0] cfg_wdata = 11'd0;

  histogram_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 10;
  int unsigned stall_cnt = 0;

  binary_projection_histogram_top uut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_kind, out_bin_value, out_column_average, out_row_average,
                        out_columns_still, out_rows_still, out_white_total});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIMIT) begin
      $display("[binary_projection_histogram_top] ERROR");
      $finish;
    end else stall_cnt <= stall_cnt + 1;
  end

  task automatic send(logic [1:0] cmd, logic [7:0] pix, logic [9:0] idx);
    start <= 1'b1;
    in_cmd <= cmd;
    in_pixel <= pix;
    in_bin_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd, pix, idx);
    if (cmd != CMD_NONE) items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_frame(logic [10:0] w, logic [10:0] h);
    settle();
    write_reg(bph_pkg::REG_FRAME_WIDTH, w);
    write_reg(bph_pkg::REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 3))
      0, 1: return 8'd255;
      2: return 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame of pixels, with reads and ignored commands mixed in
  task automatic run_frame(int unsigned npix, int unsigned read_pct);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        if ($urandom_range(0, 1)) send(bph_pkg::CMD_COL, rand_pixel(), sb.legal_index(1));
        else send(bph_pkg::CMD_ROW, rand_pixel(), sb.legal_index(0));
      end
      if ($urandom_range(0, 49) == 0) send(CMD_NONE, rand_pixel(), 10'($urandom));
      send(bph_pkg::CMD_PIXEL, rand_pixel(), 10'($urandom));
    end
  endtask

  initial begin
    int unsigned w, h;
    logic [7:0] pix_set [12];
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 frame with boundary pixel values
    pix_set = '{8'd255, 8'd254, 8'd0, 8'd255, 8'd127, 8'd255,
                8'd128, 8'd255, 8'd255, 8'd1, 8'd255, 8'd0};
    set_frame(11'd4, 11'd3);
    foreach (pix_set[i]) send(bph_pkg::CMD_PIXEL, pix_set[i], 10'd0);
    send(bph_pkg::CMD_COL, 8'd0, 10'd0);
    send(bph_pkg::CMD_COL, 8'd255, 10'd3);
    send(bph_pkg::CMD_COL, 8'd0, 10'd4);
    send(bph_pkg::CMD_COL, 8'd0, 10'd1023);
    send(bph_pkg::CMD_ROW, 8'd0, 10'd2);
    send(bph_pkg::CMD_ROW, 8'd0, 10'd3);
    send(CMD_NONE, 8'd255, 10'd1023);
    // all-black frame: maxima of zero
    set_frame(11'd2, 11'd2);
    repeat (4) send(bph_pkg::CMD_PIXEL, 8'd0, 10'd0);
    send(bph_pkg::CMD_COL, 8'd0, 10'd1);
    send(bph_pkg::CMD_ROW, 8'd0, 10'd0);

    // register extremes, clamped to the limits
    set_frame(11'd2047, 11'd0);
    run_frame(NCOL, 1);
    send(bph_pkg::CMD_COL, 8'd0, 10'd1023);
    send(bph_pkg::CMD_ROW, 8'd0, 10'd1023);

    while (items_sent < 1550) begin
      if (items_sent > 1400) idle_pct = 0;
      else if (items_sent > 1250) idle_pct = 65;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      set_frame(11'(w), 11'(h));
      run_frame(w * h, 15);
    end

    settle();
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("[binary_projection_histogram_top] OK");
    else
      $display("[binary_projection_histogram_top] ERROR");
    $finish;
  end

endmodule
